@@ design/swb_pkg.sv @@
// Shared types and constants for the sequence window buffer.
// Used by the controller, the datapath and the top level.
`default_nettype none
package swb_pkg;

   // Ring geometry and ack window size
   localparam int ENTRIES    = 256;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int ACK_WINDOW = 32;
   localparam int ACK_W      = (ACK_WINDOW > 1) ? $clog2(ACK_WINDOW) : 1;
   localparam int SEQ_W      = 16;
   localparam logic [SEQ_W-1:0] HALF_RANGE = 16'd32768;

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_FIND    = 2'd1,
      KIND_ADVANCE = 2'd2,
      KIND_ACK     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_STALE = 2'd1,
      STATUS_MISS  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_WRITE,
      ST_FIND,
      ST_FIND_CHK,
      ST_ACK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic set_stale;
      logic clr_all;
      logic clr_init;
      logic clr_step;
      logic write;
      logic rd_issue;
      logic rd_ack;
      logic find_chk;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      kind_type kind;
      logic     stale;
      logic     move;
      logic     span_all;
      logic     clr_last;
      logic     ack_last;
      logic     out_free;
   } sts_type;

   // True when a is newer than b with wraparound. A distance of exactly half
   // the range counts as newer only when a is the larger number.
   function automatic logic seq_newer(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return (d != '0) && ((d < HALF_RANGE) || ((d == HALF_RANGE) && (a > b)));
   endfunction

endpackage
`default_nettype wire

@@ design/swb_req_if.sv @@
// Request channel interface: one word per operation.
// Has no package dependencies.
`default_nettype none
interface swb_req_if;
   logic                   valid;
   logic                   ready;
   logic [1:0]             kind;
   logic [15:0]            sequence_req;
   logic [31:0]            entry_data;

   modport source (output valid, kind, sequence_req, entry_data, input ready);
   modport sink   (input valid, kind, sequence_req, entry_data, output ready);
endinterface
`default_nettype wire

@@ design/swb_rsp_if.sv @@
// Response channel interface: one result word per request.
// Has no package dependencies.
`default_nettype none
interface swb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] found_data;
   logic [15:0] ack_top_seq;
   logic [31:0] ack_mask;

   modport source (output valid, status, found_data, ack_top_seq, ack_mask, input ready);
   modport sink   (input valid, status, found_data, ack_top_seq, ack_mask, output ready);
endinterface
`default_nettype wire

@@ design/swb_ctrl.sv @@
// Controller state machine for the sequence window buffer.
// Depends on swb_pkg; drives the datapath through cmd_type.
`default_nettype none
module swb_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire swb_pkg::sts_type sts,
   output swb_pkg::cmd_type      cmd
);
   import swb_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.kind)
               KIND_INSERT, KIND_ADVANCE: begin
                  if (sts.kind == KIND_INSERT && sts.stale) begin
                     cmd.set_stale = 1'b1;
                     state_in      = ST_DONE;
                  end else if (sts.move && sts.span_all) begin
                     cmd.clr_all = 1'b1;
                     state_in    = (sts.kind == KIND_INSERT) ? ST_WRITE : ST_DONE;
                  end else if (sts.move) begin
                     cmd.clr_init = 1'b1;
                     state_in     = ST_CLEAR;
                  end else begin
                     state_in = (sts.kind == KIND_INSERT) ? ST_WRITE : ST_DONE;
                  end
               end
               KIND_FIND: begin
                  state_in = ST_FIND;
               end
               KIND_ACK: begin
                  state_in = ST_ACK;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = (sts.kind == KIND_INSERT) ? ST_WRITE : ST_DONE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_DONE;
         end
         ST_FIND: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            cmd.find_chk = 1'b1;
            state_in     = ST_DONE;
         end
         ST_ACK: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_ack   = 1'b1;
            if (sts.ack_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The last ack read is collected on the first cycle here.
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

@@ design/swb_dp.sv @@
// Datapath: head register, valid bits, tag and data memories, result register.
// Depends on swb_pkg; controlled by swb_ctrl through cmd_type.
`default_nettype none
module swb_dp #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       req_kind,
   input  wire logic [15:0]      req_sequence,
   input  wire logic [31:0]      req_data,
   input  wire swb_pkg::cmd_type cmd,
   output swb_pkg::sts_type      sts,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [31:0]           rsp_found,
   output logic [15:0]           rsp_ack_seq,
   output logic [31:0]           rsp_ack_mask
);
   import swb_pkg::*;

   logic [SEQ_W-1:0]      head_ff;
   logic [ENTRIES-1:0]    valid_ff;
   logic [SEQ_W-1:0]      tag_mem [ENTRIES];
   logic [DATA_WIDTH-1:0] data_mem [ENTRIES];

   kind_type              kind_ff;
   logic [SEQ_W-1:0]      seq_ff;
   logic [31:0]           wdata_ff;

   logic [SEQ_W-1:0]      clr_seq_ff;
   logic [IDX_W-1:0]      clr_left_ff;
   logic [SEQ_W-1:0]      ack_seq_ff;
   logic [ACK_W-1:0]      ack_idx_ff;

   logic [SEQ_W-1:0]      tag_rd_ff;
   logic [DATA_WIDTH-1:0] data_rd_ff;
   logic                  vld_rd_ff;
   logic [SEQ_W-1:0]      exp_ff;
   logic [ACK_W-1:0]      bit_ff;
   logic                  pend_ff;

   status_type            res_status_ff;
   logic [31:0]           res_found_ff;
   logic [31:0]           res_mask_ff;

   logic                  out_valid_ff;
   logic [1:0]            out_status_ff;
   logic [31:0]           out_found_ff;
   logic [15:0]           out_ack_seq_ff;
   logic [31:0]           out_mask_ff;

   logic [SEQ_W-1:0]      seq_next;
   logic [SEQ_W-1:0]      span;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   logic [63:0]           wdata_ext;
   logic [63:0]           rdata_ext;
   logic                  tag_hit;

   // Window decisions on the captured word
   assign seq_next     = seq_ff + 16'd1;
   assign span         = seq_ff - head_ff;
   assign sts.kind     = kind_ff;
   assign sts.stale    = seq_newer(head_ff - SEQ_W'(ENTRIES), seq_ff);
   assign sts.move     = seq_newer(seq_next, head_ff);
   assign sts.span_all = ({16'd0, span} >= 32'(ENTRIES));
   assign sts.clr_last = (clr_left_ff == '0);
   assign sts.ack_last = (ack_idx_ff == ACK_W'(ACK_WINDOW - 1));
   // The result is not loaded while an ack read is still folding into the mask.
   assign sts.out_free = (!out_valid_ff || rsp_ready) && !pend_ff;

   assign rd_addr   = cmd.rd_ack ? ack_seq_ff[IDX_W-1:0] : seq_ff[IDX_W-1:0];
   assign wr_addr   = seq_ff[IDX_W-1:0];
   assign wdata_ext = 64'(wdata_ff);
   assign rdata_ext = 64'(data_rd_ff);
   assign tag_hit   = vld_rd_ff && (tag_rd_ff == exp_ff);

   // Captured request word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= kind_type'(req_kind);
         seq_ff   <= req_sequence;
         wdata_ff <= req_data;
      end
   end

   // Head register and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         valid_ff <= '0;
      end else begin
         if (cmd.clr_all || cmd.clr_init) begin
            head_ff <= seq_next;
         end
         if (cmd.clr_all) begin
            valid_ff <= '0;
         end else if (cmd.clr_step) begin
            valid_ff[clr_seq_ff[IDX_W-1:0]] <= 1'b0;
         end else if (cmd.write) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Clear sweep over the skipped slots, one slot per cycle
   always_ff @(posedge clock) begin
      if (cmd.clr_init) begin
         clr_seq_ff  <= head_ff;
         clr_left_ff <= span[IDX_W-1:0];
      end else if (cmd.clr_step) begin
         clr_seq_ff  <= clr_seq_ff + 16'd1;
         clr_left_ff <= clr_left_ff - IDX_W'(1);
      end
   end

   // Tag and data memories
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         tag_mem[wr_addr]  <= seq_ff;
         data_mem[wr_addr] <= wdata_ext[DATA_WIDTH-1:0];
      end
      tag_rd_ff  <= tag_mem[rd_addr];
      data_rd_ff <= data_mem[rd_addr];
   end

   // Ack walk counters and read pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.rd_issue && cmd.rd_ack;
      end
      vld_rd_ff <= valid_ff[rd_addr];
      exp_ff    <= cmd.rd_ack ? ack_seq_ff : seq_ff;
      bit_ff    <= ack_idx_ff;
      if (cmd.capture) begin
         ack_seq_ff <= head_ff - 16'd1;
         ack_idx_ff <= '0;
      end else if (cmd.rd_issue && cmd.rd_ack) begin
         ack_seq_ff <= ack_seq_ff - 16'd1;
         ack_idx_ff <= ack_idx_ff + ACK_W'(1);
      end
   end

   // Result being built
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_status_ff <= STATUS_OK;
         res_found_ff  <= '0;
         res_mask_ff   <= '0;
      end else begin
         if (cmd.set_stale) begin
            res_status_ff <= STATUS_STALE;
         end
         if (cmd.find_chk) begin
            if (tag_hit) begin
               res_found_ff <= rdata_ext[31:0];
            end else begin
               res_status_ff <= STATUS_MISS;
            end
         end
         if (pend_ff && tag_hit) begin
            res_mask_ff[bit_ff] <= 1'b1;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_status_ff  <= res_status_ff;
         out_found_ff   <= res_found_ff;
         out_ack_seq_ff <= (kind_ff == KIND_ACK) ? head_ff - 16'd1 : '0;
         out_mask_ff    <= res_mask_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_found    = out_found_ff;
   assign rsp_ack_seq  = out_ack_seq_ff;
   assign rsp_ack_mask = out_mask_ff;

   // A stale insert never reaches the memory write.
   assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> !(sts.stale && kind_ff == KIND_INSERT))
      else $error("write issued for a stale insert");

   // A written slot is valid on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> valid_ff[$past(wr_addr)])
      else $error("written slot not marked valid");

   // A full clear empties the ring.
   assert property (@(posedge clock) disable iff (reset)
      cmd.clr_all |=> (valid_ff == '0))
      else $error("full clear left valid slots");

   // The head moves only on a head-move command.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_all || cmd.clr_init) |=> $stable(head_ff))
      else $error("head moved without a move command");

endmodule
`default_nettype wire

@@ design/sequence_window_buffer_unit.sv @@
// Top level of the sequence window buffer: controller plus datapath.
// Depends on swb_pkg, swb_req_if, swb_rsp_if, swb_ctrl and swb_dp.
//
//   channel   dir   word contents
//   req_chan  in    kind, sequence_req, entry_data
//   rsp_chan  out   status, found_data, ack_top_seq, ack_mask
//
// One request is worked at a time. The result loads once its steps are done: a
// find reads and then checks one slot; an ack query reads ACK_WINDOW slots, one
// tag read per cycle; an insert writes its slot; a partial clear sweep clears each
// skipped slot in turn (up to ENTRIES). The next word is accepted in the cycle
// after the result loads. Reset is synchronous; the ring is empty after reset with
// no clearing pass. A loaded result waits in the output register while the next
// word is worked; that word's result stalls until it frees.
`default_nettype none
module sequence_window_buffer_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   swb_req_if.sink    req_chan,
   swb_rsp_if.source  rsp_chan
);
   import swb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencing of each request
   swb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and result path
   swb_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_kind     (req_chan.kind),
      .req_sequence (req_chan.sequence_req),
      .req_data     (req_chan.entry_data),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_status   (rsp_chan.status),
      .rsp_found    (rsp_chan.found_data),
      .rsp_ack_seq  (rsp_chan.ack_top_seq),
      .rsp_ack_mask (rsp_chan.ack_mask)
   );

endmodule
`default_nettype wire
